/* design/ufd_pkg.sv */
`default_nettype none

package ufd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W = 21;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

	// one byte's burst: rep_count replacements, then the tail result
	typedef struct packed {
		logic [1:0]      rep_count;
		logic [CP_W-1:0] tail_cp;
		logic            tail_rep;
		logic            fin;
	} cmd_t;

endpackage

`default_nettype wire

/* design/ufd_if.sv */
`default_nettype none

interface ufd_in_if;
	logic                        valid;
	logic                        ready;
	logic [ufd_pkg::BYTE_W-1:0]  text_byte;
	logic                        final_byte;

	modport source (output valid, output text_byte, output final_byte, input ready);
	modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

interface ufd_out_if;
	logic                      valid;
	logic                      ready;
	logic [ufd_pkg::CP_W-1:0]  code_point;
	logic                      replaced;
	logic                      run_end;
	logic                      text_end;

	modport source (output valid, output code_point, output replaced, output run_end,
		output text_end, input ready);
	modport sink (input valid, input code_point, input replaced, input run_end,
		input text_end, output ready);
endinterface

`default_nettype wire

/* design/ufd_front.sv */
`default_nettype none

module ufd_front (
	input  wire logic    clk,
	input  wire logic    arst_n,
	ufd_in_if.sink       text_ch,
	input  wire logic    full,
	output logic         push,
	output ufd_pkg::cmd_t push_cmd
);

	logic [1:0]                exp_q, exp_d;
	logic [1:0]                tk_q, tk_d;
	logic [ufd_pkg::CP_W-1:0]  pv_q, pv_d;

	logic [7:0]                b;
	logic                      fin;
	logic                      open_seq;
	logic                      is_cont;
	logic                      is_ascii;
	logic                      is_bad;
	logic [1:0]                need;
	logic [ufd_pkg::CP_W-1:0]  bits;
	logic [2:0]                taken;
	logic [1:0]                pre;
	logic [ufd_pkg::CP_W-1:0]  pv_next;
	logic                      emit;
	logic                      accept;

	assign b = text_ch.text_byte;
	assign fin = text_ch.final_byte;
	assign text_ch.ready = !full;
	assign accept = text_ch.valid && text_ch.ready;
	assign open_seq = (exp_q != 2'd0);
	assign is_cont = (b[7:6] == 2'b10);
	assign taken = {1'b0, tk_q} + 3'd1;
	assign pv_next = {pv_q[ufd_pkg::CP_W-7:0], b[5:0]};
	// open sequence always has tk_q below exp_q, so this fits
	assign pre = open_seq ? taken[1:0] : 2'd0;

	// lead classification
	always_comb begin
		is_ascii = 1'b0;
		is_bad = 1'b0;
		need = 2'd0;
		bits = '0;
		priority if (b[7] == 1'b0) begin
			is_ascii = 1'b1;
		end else if (b[7:5] == 3'b110) begin
			need = 2'd1;
			bits = {16'd0, b[4:0]};
		end else if (b[7:4] == 4'b1110) begin
			need = 2'd2;
			bits = {17'd0, b[3:0]};
		end else if (b[7:3] == 5'b11110) begin
			need = 2'd3;
			bits = {18'd0, b[2:0]};
		end else begin
			is_bad = 1'b1;
		end
	end

	always_comb begin
		emit = 1'b0;
		push_cmd = '0;
		push_cmd.fin = fin;
		exp_d = exp_q;
		tk_d = tk_q;
		pv_d = pv_q;
		if (open_seq && is_cont) begin
			if (taken == {1'b0, exp_q}) begin
				emit = 1'b1;
				push_cmd.tail_cp = pv_next;
				exp_d = 2'd0;
				tk_d = 2'd0;
				pv_d = '0;
			end else if (fin) begin
				// flush lead and the taken continuations, this byte included
				emit = 1'b1;
				push_cmd.rep_count = taken[1:0];
				push_cmd.tail_cp = ufd_pkg::REPLACEMENT_CP;
				push_cmd.tail_rep = 1'b1;
			end else begin
				tk_d = taken[1:0];
				pv_d = pv_next;
			end
		end else begin
			exp_d = 2'd0;
			tk_d = 2'd0;
			pv_d = '0;
			push_cmd.rep_count = pre;
			push_cmd.tail_cp = ufd_pkg::REPLACEMENT_CP;
			push_cmd.tail_rep = 1'b1;
			priority if (is_ascii) begin
				emit = 1'b1;
				push_cmd.tail_cp = {13'd0, b};
				push_cmd.tail_rep = 1'b0;
			end else if (is_bad || fin) begin
				emit = 1'b1;
			end else begin
				// new sequence opens; broken one before it still flushes
				emit = open_seq;
				push_cmd.rep_count = pre - 2'd1;
				exp_d = need;
				pv_d = bits;
			end
		end
		if (fin) begin
			exp_d = 2'd0;
			tk_d = 2'd0;
			pv_d = '0;
		end
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= 2'd0;
			tk_q <= 2'd0;
			pv_q <= '0;
		end else if (accept) begin
			exp_q <= exp_d;
			tk_q <= tk_d;
			pv_q <= pv_d;
		end
	end

endmodule

`default_nettype wire

/* design/ufd_queue.sv */
`default_nettype none

module ufd_queue #(
	parameter int unsigned DEPTH = ufd_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire ufd_pkg::cmd_t push_cmd,
	output logic               full,
	input  wire logic          pop,
	output logic               head_valid,
	output ufd_pkg::cmd_t      head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	ufd_pkg::cmd_t     slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* design/ufd_back.sv */
`default_nettype none

module ufd_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire ufd_pkg::cmd_t head,
	output logic               pop,
	ufd_out_if.source          cp_ch
);

	logic [1:0]                idx_q;
	logic                      valid_q;
	logic [ufd_pkg::CP_W-1:0]  cp_q;
	logic                      rep_q;
	logic                      run_end_q;
	logic                      text_end_q;
	logic                      load;
	logic                      at_tail;

	assign load = head_valid && (!valid_q || cp_ch.ready);
	assign at_tail = (idx_q == head.rep_count);
	assign pop = load && at_tail;

	assign cp_ch.valid = valid_q;
	assign cp_ch.code_point = cp_q;
	assign cp_ch.replaced = rep_q;
	assign cp_ch.run_end = run_end_q;
	assign cp_ch.text_end = text_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q <= at_tail ? 2'd0 : idx_q + 2'd1;
			end else if (cp_ch.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output word register, no reset needed
	always_ff @(posedge clk) begin
		if (load) begin
			if (at_tail) begin
				cp_q <= head.tail_cp;
				rep_q <= head.tail_rep;
				run_end_q <= 1'b1;
				text_end_q <= head.fin;
			end else begin
				cp_q <= ufd_pkg::REPLACEMENT_CP;
				rep_q <= 1'b1;
				run_end_q <= 1'b0;
				text_end_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* design/utf8_stream_decoder.sv */
// UTF-8 stream decoder: takes one text byte per cycle on text_ch (with final_byte on the last
// byte of the text) and returns code points on cp_ch, one word per cycle. A byte gives zero
// to four words: a run of U+FFFD replacements for a broken sequence, then at most one decoded
// value or replacement, with run_end set on the last word of the byte and text_end on the last
// word of the text. Bytes are taken every cycle while the command queue between the byte
// parser and the output stage has room (QUEUE_DEPTH entries); the output stage drains one word
// per cycle while cp_ch.ready is high, so a byte that yields several words holds the output
// longer; bytes go one per cycle for plain text and slower when replacement bursts pile up.
`default_nettype none

module utf8_stream_decoder #(
	parameter int unsigned QUEUE_DEPTH = ufd_pkg::QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ufd_in_if.sink    text_ch,
	ufd_out_if.source cp_ch
);

	logic          push;
	ufd_pkg::cmd_t push_cmd;
	logic          full;
	logic          pop;
	logic          head_valid;
	ufd_pkg::cmd_t head;

	ufd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_ch  (text_ch),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	ufd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	ufd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.cp_ch      (cp_ch)
	);

endmodule

`default_nettype wire

/* test/utf8_stream_decoder_checker.sv */
module utf8_stream_decoder_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       text_valid,
	input  logic                       text_ready,
	input  logic [ufd_pkg::BYTE_W-1:0] text_byte,
	input  logic                       final_byte,
	input  logic                       cp_valid,
	input  logic                       cp_ready,
	input  logic [ufd_pkg::CP_W-1:0]   code_point,
	input  logic                       replaced,
	input  logic                       run_end,
	input  logic                       text_end,
	output int                         fail_count,
	output int                         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CONT_TAG  = 2'b10;
	localparam logic [2:0] LEAD2_TAG = 3'b110;
	localparam logic [3:0] LEAD3_TAG = 4'b1110;
	localparam logic [4:0] LEAD4_TAG = 5'b11110;

	typedef struct packed {
		logic [ufd_pkg::CP_W-1:0] code_point;
		logic                     replaced;
		logic                     run_end;
		logic                     text_end;
	} cp_word_t;

	// open sequence: continuation bytes needed, taken so far, bits gathered
	logic [1:0]               seq_need;
	logic [1:0]               seq_taken;
	logic [ufd_pkg::CP_W-1:0] seq_bits;

	cp_word_t decoded_q [$];
	cp_word_t burst [4];
	int       burst_len;
	cp_word_t want_w;
	cp_word_t got_w;

	task automatic stage_word(input logic [ufd_pkg::CP_W-1:0] value, input logic is_repl);
		burst[burst_len] = '{code_point: value, replaced: is_repl, run_end: 1'b0,
			text_end: 1'b0};
		burst_len++;
	endtask

	task automatic close_seq();
		seq_need = '0;
		seq_taken = '0;
		seq_bits = '0;
	endtask

	task automatic decode_byte(input logic [ufd_pkg::BYTE_W-1:0] b, input logic fin);
		logic                     used;
		logic [1:0]               need;
		logic [ufd_pkg::CP_W-1:0] bits;
		logic [2:0]               taken;
		burst_len = 0;
		used = 1'b0;
		need = '0;
		bits = '0;
		if (seq_need != 0) begin
			if (b[7:6] == CONT_TAG) begin
				taken = {1'b0, seq_taken} + 3'd1;
				seq_bits = {seq_bits[ufd_pkg::CP_W-7:0], b[5:0]};
				used = 1'b1;
				if (taken == {1'b0, seq_need}) begin
					stage_word(seq_bits, 1'b0);
					close_seq();
				end else if (fin) begin
					repeat (int'(taken) + 1) stage_word(ufd_pkg::REPLACEMENT_CP, 1'b1);
					close_seq();
				end else begin
					seq_taken = taken[1:0];
				end
			end else begin
				// broken sequence: flush it, then treat this byte as a lead
				repeat (int'(seq_taken) + 1) stage_word(ufd_pkg::REPLACEMENT_CP, 1'b1);
				close_seq();
			end
		end
		if (!used) begin
			if (!b[7]) begin
				stage_word({{(ufd_pkg::CP_W-ufd_pkg::BYTE_W){1'b0}}, b}, 1'b0);
			end else if (b[7:5] == LEAD2_TAG) begin
				need = 2'd1;
				bits = {{(ufd_pkg::CP_W-5){1'b0}}, b[4:0]};
			end else if (b[7:4] == LEAD3_TAG) begin
				need = 2'd2;
				bits = {{(ufd_pkg::CP_W-4){1'b0}}, b[3:0]};
			end else if (b[7:3] == LEAD4_TAG) begin
				need = 2'd3;
				bits = {{(ufd_pkg::CP_W-3){1'b0}}, b[2:0]};
			end else begin
				stage_word(ufd_pkg::REPLACEMENT_CP, 1'b1);
			end
			if (need != 0) begin
				if (fin) begin
					stage_word(ufd_pkg::REPLACEMENT_CP, 1'b1);
				end else begin
					seq_need = need;
					seq_taken = '0;
					seq_bits = bits;
				end
			end
		end
		if (fin)
			close_seq();
		if (burst_len > 0) begin
			burst[burst_len-1].run_end = 1'b1;
			burst[burst_len-1].text_end = fin;
		end
		for (int k = 0; k < burst_len; k++)
			decoded_q = {decoded_q, burst[k]};
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_seq();
			decoded_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (text_valid && text_ready)
				decode_byte(text_byte, final_byte);
			if (cp_valid && cp_ready) begin
				got_w = '{code_point: code_point, replaced: replaced, run_end: run_end,
					text_end: text_end};
				if (decoded_q.size() == 0) begin
					$display("%t unexpected word: cp=%h rep=%b run_end=%b text_end=%b",
						$time, got_w.code_point, got_w.replaced, got_w.run_end, got_w.text_end);
					fail_count <= fail_count + 1;
				end else begin
					want_w = decoded_q.pop_front();
					if (got_w.code_point != want_w.code_point || got_w.replaced != want_w.replaced
						|| got_w.run_end != want_w.run_end
						|| got_w.text_end != want_w.text_end) begin
						$display("%t mismatch: expected cp=%h rep=%b run_end=%b text_end=%b",
							$time, want_w.code_point, want_w.replaced, want_w.run_end,
							want_w.text_end);
						$display("%t            actual cp=%h rep=%b run_end=%b text_end=%b",
							$time, got_w.code_point, got_w.replaced, got_w.run_end,
							got_w.text_end);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= decoded_q.size();
		end
	end

endmodule

/* test/utf8_stream_decoder_test.sv */
module utf8_stream_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOTAL_BYTES    = 380;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 20;

	// {final_byte, text_byte}
	localparam logic [8:0] DIRECTED [23] = '{
		9'h000, 9'h07F,                  // ascii extremes
		9'h0C3, 9'h1A9,                  // two-byte, ends the text
		9'h0E2, 9'h082, 9'h0AC,          // three-byte
		9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,  // largest four-byte value
		9'h080, 9'h1FF,                  // bad leads, last one ends the text
		9'h0E2, 9'h041,                  // bad continuation right after the lead
		9'h0F0, 9'h09F, 9'h080, 9'h141,  // bad continuation after two taken
		9'h1E2,                          // multi-byte lead as the final byte
		9'h0F0, 9'h09F, 9'h198           // text ends inside a sequence
	};

	logic clk;
	logic arst_n;
	logic idle_on;
	logic hold_req;
	logic pressure_done;
	int   sent;
	int   fail_count;
	int   pending;

	ufd_in_if  text_ch ();
	ufd_out_if cp_ch ();

	utf8_stream_decoder i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.text_ch (text_ch),
		.cp_ch   (cp_ch)
	);

	utf8_stream_decoder_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_ch.valid),
		.text_ready (text_ch.ready),
		.text_byte  (text_ch.text_byte),
		.final_byte (text_ch.final_byte),
		.cp_valid   (cp_ch.valid),
		.cp_ready   (cp_ch.ready),
		.code_point (cp_ch.code_point),
		.replaced   (cp_ch.replaced),
		.run_end    (cp_ch.run_end),
		.text_end   (cp_ch.text_end),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		while (idle_on && $urandom_range(99) < 12) begin
			text_ch.valid <= 1'b0;
			@(posedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.text_byte <= b;
		text_ch.final_byte <= fin;
		do
			@(posedge clk);
		while (!text_ch.ready);
		sent++;
	endtask

	// one text: mostly well-formed sequences, some cut short, some random bytes
	task automatic send_text();
		logic [7:0] text_q [$];
		int         elems;
		int         e;
		int         kind;
		int         len;
		int         conts;
		elems = $urandom_range(10, 1);
		for (e = 0; e < elems; e++) begin
			kind = $urandom_range(99);
			len = $urandom_range(4, 1);
			if (kind >= 85) begin
				text_q = {text_q, 8'($urandom_range(255))};
			end else begin
				if (kind >= 70 && len == 1)
					len = $urandom_range(4, 2);
				case (len)
					1: text_q = {text_q, {1'b0, 7'($urandom)}};
					2: text_q = {text_q, {3'b110, 5'($urandom)}};
					3: text_q = {text_q, {4'b1110, 4'($urandom)}};
					default: text_q = {text_q, {5'b11110, 3'($urandom)}};
				endcase
				conts = (kind >= 70) ? $urandom_range(len - 2, 0) : len - 1;
				repeat (conts) text_q = {text_q, {2'b10, 6'($urandom)}};
			end
		end
		foreach (text_q[k])
			send_byte(text_q[k], k == text_q.size() - 1);
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		cp_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				cp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			cp_ch.ready <= !(idle_on && $urandom_range(99) < 12);
			@(posedge clk);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((text_ch.valid && text_ch.ready) || (cp_ch.valid && cp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		text_ch.valid = 1'b0;
		text_ch.text_byte = '0;
		text_ch.final_byte = 1'b0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		pressure_done = 1'b0;
		sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED[k])
			send_byte(DIRECTED[k][7:0], DIRECTED[k][8]);
		while (sent < TOTAL_BYTES) begin
			// a stretch with no idling on either side
			idle_on = !(sent >= 150 && sent < 250);
			if (!pressure_done && sent >= 300) begin
				hold_req = 1'b1;
				pressure_done = 1'b1;
			end
			send_text();
		end
		text_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
